// ===== hw/rtl/smpq_pkg.sv =====
// Shared types and constants for the sorted min priority queue.
package smpq_pkg;

   localparam int DEPTH       = 16;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int ENTRY_CNT_W = 5;

   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic      ins;
      logic      rem;
      value_type value;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/smpq_cell.sv =====
// One slot of the sorted chain: holds a value and shifts on insert or remove.
module smpq_cell (
   input  logic                   clock,
   input  smpq_pkg::cell_ctrl_type ctrl,
   input  logic                   occ,
   input  logic                   left_gt,
   input  smpq_pkg::value_type    left_data,
   input  smpq_pkg::value_type    right_data,
   output logic                   gt,
   output smpq_pkg::value_type    data
);

   smpq_pkg::value_type data_ff;
   smpq_pkg::value_type data_in;

   assign gt   = !occ || (data_ff > ctrl.value);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins && gt) begin
         data_in = left_gt ? left_data : ctrl.value;
      end else if (ctrl.rem) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hw/rtl/sorted_min_priority_queue_unit.sv =====
// Top level of the sorted min priority queue built as a chain of cells.
//
// Input words arrive on req_: req_tuser carries the command (insert or remove
// smallest) and req_tdata the signed value to insert. Every accepted word
// yields exactly one response word on rsp_ with the removed value, a status
// and the number of entries held afterwards.
// The store is a row of DEPTH cells in ascending order. On insert every cell
// compares its value with the new one in parallel and the tail shifts right
// by one; on remove the whole row shifts left by one. One word is taken per
// cycle while the output register is free or being read, and the response
// appears in the output register in the cycle after the word is accepted. The
// row keeps that rate for any mix of commands, as all cells compare at once.
// The output register frees as it is read, so a new word is taken in the
// same cycle that a waiting response is taken. While the receiver stalls with
// a response waiting, req_tready stays low and the queue state holds.
// Reset empties the queue at once; no clearing pass is needed, since cells
// beyond the entry count are never read.
module sorted_min_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [0:0]  req_tuser,  // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [31:0] removed_value, [33:32] status,
                                   // [38:34] entry_count, [39] zero
);

   smpq_pkg::cnt_type       count_ff;
   smpq_pkg::cnt_type       count_in;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tvalid_in;
   smpq_pkg::value_type     removed_ff;
   smpq_pkg::value_type     removed_in;
   smpq_pkg::status_type    status_ff;
   smpq_pkg::status_type    status_in;
   logic [smpq_pkg::ENTRY_CNT_W-1:0] entry_ff;
   logic [smpq_pkg::ENTRY_CNT_W-1:0] entry_in;
   logic [smpq_pkg::CNT_W+smpq_pkg::ENTRY_CNT_W-1:0] count_wide;

   smpq_pkg::cmd_type       cmd;
   smpq_pkg::cell_ctrl_type ctrl;
   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    do_ins;
   logic                    do_rem;

   logic [smpq_pkg::DEPTH-1:0] occ;
   logic [smpq_pkg::DEPTH-1:0] gt;
   smpq_pkg::value_type        data [smpq_pkg::DEPTH];

   assign cmd        = smpq_pkg::cmd_type'(req_tuser[0]);
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff == smpq_pkg::cnt_type'(smpq_pkg::DEPTH);
   assign empty      = count_ff == '0;
   assign do_ins     = accept && (cmd == smpq_pkg::CMD_INSERT) && !full;
   assign do_rem     = accept && (cmd == smpq_pkg::CMD_REMOVE) && !empty;

   assign ctrl.ins   = do_ins;
   assign ctrl.rem   = do_rem;
   assign ctrl.value = req_tdata;

   for (genvar g = 0; g < smpq_pkg::DEPTH; g++) begin : g_cell
      assign occ[g] = count_ff > smpq_pkg::cnt_type'(g);

      if (g == 0) begin : g_head
         if (smpq_pkg::DEPTH == 1) begin : g_only
            smpq_cell u_cell (
               .clock      (clock),
               .ctrl       (ctrl),
               .occ        (occ[g]),
               .left_gt    (1'b0),
               .left_data  (req_tdata),
               .right_data (data[g]),
               .gt         (gt[g]),
               .data       (data[g])
            );
         end else begin : g_first
            smpq_cell u_cell (
               .clock      (clock),
               .ctrl       (ctrl),
               .occ        (occ[g]),
               .left_gt    (1'b0),
               .left_data  (req_tdata),
               .right_data (data[g+1]),
               .gt         (gt[g]),
               .data       (data[g])
            );
         end
      end else if (g == smpq_pkg::DEPTH - 1) begin : g_tail
         smpq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occ        (occ[g]),
            .left_gt    (gt[g-1]),
            .left_data  (data[g-1]),
            .right_data (data[g]),
            .gt         (gt[g]),
            .data       (data[g])
         );
      end else begin : g_mid
         smpq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occ        (occ[g]),
            .left_gt    (gt[g-1]),
            .left_data  (data[g-1]),
            .right_data (data[g+1]),
            .gt         (gt[g]),
            .data       (data[g])
         );
      end
   end

   always_comb begin
      count_in   = count_ff;
      removed_in = '0;
      status_in  = smpq_pkg::STATUS_OK;
      case (cmd)
         smpq_pkg::CMD_INSERT: begin
            if (full) begin
               status_in = smpq_pkg::STATUS_FULL;
            end else if (accept) begin
               count_in = count_ff + 1'b1;
            end
         end
         smpq_pkg::CMD_REMOVE: begin
            if (empty) begin
               status_in = smpq_pkg::STATUS_EMPTY;
            end else begin
               removed_in = data[0];
               if (accept) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      count_wide = {{smpq_pkg::ENTRY_CNT_W{1'b0}}, count_in};
      entry_in   = count_wide[smpq_pkg::ENTRY_CNT_W-1:0];
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
         entry_ff   <= entry_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, entry_ff, status_ff, removed_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= smpq_pkg::cnt_type'(smpq_pkg::DEPTH))
      else $error("entry count exceeds capacity");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (cmd == smpq_pkg::CMD_INSERT) && full |=> count_ff == $past(count_ff))
      else $error("rejected insert changed the entry count");

   a_remove_head: assert property (@(posedge clock) disable iff (reset)
      do_rem |=> (removed_ff == $past(data[0])) && (count_ff == $past(count_ff) - 1'b1))
      else $error("remove did not return the head or drop one entry");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> $stable(count_ff))
      else $error("queue changed while the response was stalled");

endmodule

// ===== test/sorted_min_priority_queue_unit_test.sv =====
// Self-checking testbench for the sorted min priority queue with a directed table and random runs.
`timescale 1ns / 100ps

module sorted_min_priority_queue_unit_test;

   localparam int MAX_GAP        = 14;
   localparam int LONG_HOLD      = 120;
   localparam int HOLD_AFTER     = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = 128;
   localparam int DIRECTED_ROWS  = 24;
   localparam int EXPECT_SLOTS   = 16;

   typedef struct packed {
      smpq_pkg::value_type                  removed;
      smpq_pkg::status_type                 status;
      logic [smpq_pkg::ENTRY_CNT_W-1:0]     count;
   } dequeue_result_type;

   typedef struct {
      smpq_pkg::cmd_type   cmd;
      smpq_pkg::value_type value;
      bit                  typed;
      dequeue_result_type  result;
   } queue_stimulus_row_type;

   localparam dequeue_result_type UNTYPED = '0;
   localparam smpq_pkg::value_type VAL_MIN = 32'sh8000_0000;
   localparam smpq_pkg::value_type VAL_MAX = 32'sh7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value
   logic [0:0]  req_tuser = smpq_pkg::CMD_INSERT;  // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] removed_value, [33:32] status,
                                   // [38:34] entry_count, [39] zero

   smpq_pkg::value_type queue_store [smpq_pkg::DEPTH];
   int unsigned         queue_fill;
   dequeue_result_type  expected_results [EXPECT_SLOTS];
   int unsigned         expect_written = 0;
   int unsigned         expect_taken = 0;
   bit                  idle_enabled = 1'b1;
   int                  error_count;
   int                  responses_checked;
   int                  inserts_sent;
   int                  removes_sent;
   int                  full_rejects;
   int                  empty_removes;

   queue_stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{smpq_pkg::CMD_REMOVE, 32'sh1234_5678, 1'b1, '{32'sd0, smpq_pkg::STATUS_EMPTY, 5'd0}},
      '{smpq_pkg::CMD_INSERT, VAL_MAX,        1'b1, '{32'sd0, smpq_pkg::STATUS_OK, 5'd1}},
      '{smpq_pkg::CMD_INSERT, VAL_MIN,        1'b1, '{32'sd0, smpq_pkg::STATUS_OK, 5'd2}},
      '{smpq_pkg::CMD_REMOVE, -32'sd1,        1'b1, '{VAL_MIN, smpq_pkg::STATUS_OK, 5'd1}},
      '{smpq_pkg::CMD_REMOVE, 32'sd0,         1'b1, '{VAL_MAX, smpq_pkg::STATUS_OK, 5'd0}},
      '{smpq_pkg::CMD_REMOVE, VAL_MAX,        1'b1, '{32'sd0, smpq_pkg::STATUS_EMPTY, 5'd0}},
      '{smpq_pkg::CMD_INSERT, 32'sd5,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, -32'sd1,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd5,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd0,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, VAL_MAX,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, VAL_MIN,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd100,       1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, -32'sd100,      1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd5,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd1,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd2,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd3,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, -32'sd1,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd6,         1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, VAL_MAX,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, VAL_MIN,        1'b0, UNTYPED},
      '{smpq_pkg::CMD_INSERT, 32'sd42,        1'b1, '{32'sd0, smpq_pkg::STATUS_FULL, 5'd16}},
      '{smpq_pkg::CMD_REMOVE, 32'sd0,         1'b0, UNTYPED}
   };

   int insert_percent [PHASES] = '{85, 15, 50, 90, 10, 55, 70, 30};

   sorted_min_priority_queue_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic dequeue_result_type predict_queue_step(smpq_pkg::cmd_type cmd,
                                                             smpq_pkg::value_type value);
      dequeue_result_type r;
      int unsigned        pos;
      int unsigned        i;
      r = '0;
      r.status = smpq_pkg::STATUS_OK;
      if (cmd == smpq_pkg::CMD_INSERT) begin
         inserts_sent++;
         if (queue_fill >= smpq_pkg::DEPTH) begin
            r.status = smpq_pkg::STATUS_FULL;
            full_rejects++;
         end else begin
            // Equal values stay ahead of the new one, so search for the first strictly greater.
            pos = queue_fill;
            for (i = 0; i < queue_fill; i++) begin
               if (queue_store[i] > value) begin
                  pos = i;
                  break;
               end
            end
            for (i = queue_fill; i > pos; i--) begin
               queue_store[i] = queue_store[i-1];
            end
            queue_store[pos] = value;
            queue_fill++;
         end
      end else begin
         removes_sent++;
         if (queue_fill == 0) begin
            r.status = smpq_pkg::STATUS_EMPTY;
            empty_removes++;
         end else begin
            r.removed = queue_store[0];
            for (i = 1; i < queue_fill; i++) begin
               queue_store[i-1] = queue_store[i];
            end
            queue_fill--;
         end
      end
      r.count = queue_fill[smpq_pkg::ENTRY_CNT_W-1:0];
      return r;
   endfunction

   task automatic send_word(input smpq_pkg::cmd_type cmd, input smpq_pkg::value_type value,
                            input bit typed, input dequeue_result_type typed_result);
      int                 gap;
      dequeue_result_type predicted;
      gap = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = predict_queue_step(cmd, value);
      expected_results[expect_written % EXPECT_SLOTS] = typed ? typed_result : predicted;
      expect_written++;
   endtask

   task automatic drain_queue();
      req_tvalid <= 1'b0;
      while (expect_written != expect_taken) @(posedge clock);
   endtask

   initial begin : response_side
      int                 gap;
      bit                 long_hold_done;
      dequeue_result_type seen;
      dequeue_result_type want;
      long_hold_done = 1'b0;
      wait (!reset);
      forever begin
         gap = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
         // One long stall lets the output register back up into the request side.
         if (!long_hold_done && responses_checked >= HOLD_AFTER) begin
            gap = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen.removed = rsp_tdata[31:0];
         seen.status  = smpq_pkg::status_type'(rsp_tdata[33:32]);
         seen.count   = rsp_tdata[38:34];
         if (expect_written == expect_taken) begin
            $display("%0t: response word with nothing expected: removed %0d status %0d count %0d",
                     $time, seen.removed, seen.status, seen.count);
            error_count++;
         end else begin
            want = expected_results[expect_taken % EXPECT_SLOTS];
            expect_taken++;
            if (seen.removed !== want.removed) begin
               $display("%0t: removed_value expected %0d actual %0d",
                        $time, want.removed, seen.removed);
               error_count++;
            end
            if (seen.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
               error_count++;
            end
            if (seen.count !== want.count) begin
               $display("%0t: entry_count expected %0d actual %0d",
                        $time, want.count, seen.count);
               error_count++;
            end
         end
         responses_checked++;
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : request_side
      int                  p;
      int                  n;
      smpq_pkg::cmd_type   cmd;
      smpq_pkg::value_type value;
      queue_fill = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send_word(directed_rows[n].cmd, directed_rows[n].value, directed_rows[n].typed,
                   directed_rows[n].result);
      end
      drain_queue();

      // Phases mix filling, draining and balanced command shares, with value sets that
      // are wide, clustered with many duplicates, or weighted toward the extremes and zero.
      for (p = 0; p < PHASES; p++) begin
         idle_enabled = (p != 2) && (p != 5);
         for (n = 0; n < PHASE_WORDS; n++) begin
            cmd = ($urandom_range(0, 99) < insert_percent[p]) ? smpq_pkg::CMD_INSERT :
                                                                 smpq_pkg::CMD_REMOVE;
            case (p % 3)
               0: value = $urandom;
               1: value = smpq_pkg::value_type'($urandom_range(0, 16)) - 32'sd8;
               default: begin
                  case ($urandom_range(0, 5))
                     0: value = VAL_MIN;
                     1: value = VAL_MAX;
                     2: value = -32'sd1;
                     3: value = 32'sd0;
                     4: value = 32'sd1;
                     default: value = $urandom;
                  endcase
               end
            endcase
            send_word(cmd, value, 1'b0, UNTYPED);
         end
         drain_queue();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d inserts and %0d removes; %0d inserts hit a full queue,",
               inserts_sent, removes_sent, full_rejects);
      $display("%0d removes an empty one; checked %0d response words with %0d mismatches.",
               empty_removes, responses_checked, error_count);
      if (error_count == 0 && expect_written == expect_taken)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue_unit.sv
test/sorted_min_priority_queue_unit_test.sv
